// ===== src/elh_pkg.sv =====
// ----------------------------------------------------------------------------
// Event latency histogram package
// Shared sizes, codes and the records that pass between the front end, the
// command queue and the histogram back end.
// ----------------------------------------------------------------------------
package elh_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int HIST_IDS      = 512;
    localparam int HIST_BUCKETS  = 36;
    localparam int NS_PER_US     = 1000;

    localparam int TAB_AW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TAB_CW     = $clog2(TABLE_ENTRIES + 1);
    localparam int HID_W      = (HIST_IDS > 1) ? $clog2(HIST_IDS) : 1;
    localparam int HIST_DEPTH = HIST_IDS * HIST_BUCKETS;
    localparam int HADDR_W    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    // Wide enough for NS_PER_US shifted left by up to 63 bucket steps.
    localparam int THR_W      = 74;

    typedef logic [2:0] status_t;

    localparam status_t ST_IGNORED  = 3'd0;
    localparam status_t ST_STORED   = 3'd1;
    localparam status_t ST_FULL     = 3'd2;
    localparam status_t ST_NO_START = 3'd3;
    localparam status_t ST_COUNTED  = 3'd4;
    localparam status_t ST_READ     = 3'd5;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_END   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [3:0] CFG_ONLY_PROCESS = 4'd0;
    localparam logic [3:0] CFG_ONLY_EVENT   = 4'd1;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_COUNT,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t              op;
        status_t          status;
        logic [HID_W-1:0] hist_id;
        logic [5:0]       bucket;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  bucket;
        logic [63:0] count;
    } result_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

// ===== src/elh_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue that decouples the front end from the histogram back end.
// ----------------------------------------------------------------------------
module elh_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  elh_pkg::cmd_t din,
    input  logic          pop,
    output logic          empty,
    output elh_pkg::cmd_t dout
);

    elh_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== src/elh_front.sv =====
// ----------------------------------------------------------------------------
// Front end
// Accepts items, applies the filters, keeps the start table and works out
// the log2 bucket of a finished event, then queues one command per item.
// ----------------------------------------------------------------------------
module elh_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            action,
    input  logic [31:0]           process_id,
    input  logic [15:0]           event_id,
    input  logic [63:0]           time_ns,
    input  logic [5:0]            bucket_select,
    input  logic [31:0]           only_process,
    input  logic [15:0]           only_event,
    input  elh_pkg::back_status_t back_status,
    output logic                  cmd_push,
    output elh_pkg::cmd_t         cmd,
    input  logic                  cmd_full
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_LOG,
        S_EMIT
    } state_t;

    state_t                       state_reg, state_next;
    logic [1:0]                   act_reg, act_next;
    logic [31:0]                  pid_reg, pid_next;
    logic [15:0]                  ev_reg, ev_next;
    logic [63:0]                  now_reg, now_next;
    logic [elh_pkg::TAB_CW-1:0]   fill_reg, fill_next;
    logic [elh_pkg::TAB_CW-1:0]   issue_reg, issue_next;
    logic                         pend_reg, pend_next;
    logic [elh_pkg::TAB_AW-1:0]   pend_idx_reg, pend_idx_next;
    logic [elh_pkg::TAB_AW-1:0]   hit_idx_reg, hit_idx_next;
    logic [63:0]                  diff_reg, diff_next;
    logic [elh_pkg::THR_W-1:0]    thr_reg, thr_next;
    logic [5:0]                   bkt_reg, bkt_next;
    elh_pkg::cmd_t                cmd_reg, cmd_next;

    logic [31:0]                  owner_mem [elh_pkg::TABLE_ENTRIES];
    logic [63:0]                  time_mem  [elh_pkg::TABLE_ENTRIES];
    logic [31:0]                  owner_q;
    logic [63:0]                  time_q;
    logic [elh_pkg::TAB_AW-1:0]   rd_addr;
    logic                         wr_en;
    logic [elh_pkg::TAB_AW-1:0]   wr_addr;
    logic                         wr_owner_en;
    logic [31:0]                  wr_owner;
    logic [63:0]                  wr_time;

    logic                         accept;
    logic                         pass;
    logic                         issuing;
    logic                         hit;
    logic                         ev_in_range;
    logic                         in_ev_in_range;
    logic                         sel_in_range;

    assign full     = (state_reg != S_IDLE) || back_status.clearing;
    assign accept   = push && !full;
    assign cmd_push = (state_reg == S_EMIT) && !cmd_full;
    assign cmd      = cmd_reg;

    assign pass = !((only_event != 16'd0) && (event_id != only_event)) &&
                  !((only_process != 32'd0) && (process_id != only_process));

    assign issuing        = (issue_reg < fill_reg);
    assign hit            = pend_reg && (owner_q == pid_reg);
    assign ev_in_range    = (17'(ev_reg) < 17'(elh_pkg::HIST_IDS));
    assign in_ev_in_range = (17'(event_id) < 17'(elh_pkg::HIST_IDS));
    assign sel_in_range   = (7'(bucket_select) < 7'(elh_pkg::HIST_BUCKETS));

    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        pid_next      = pid_reg;
        ev_next       = ev_reg;
        now_next      = now_reg;
        fill_next     = fill_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        hit_idx_next  = hit_idx_reg;
        diff_next     = diff_reg;
        thr_next      = thr_reg;
        bkt_next      = bkt_reg;
        cmd_next      = cmd_reg;
        rd_addr       = issue_reg[elh_pkg::TAB_AW-1:0];
        wr_en         = 1'b0;
        wr_owner_en   = 1'b0;
        wr_addr       = fill_reg[elh_pkg::TAB_AW-1:0];
        wr_owner      = pid_reg;
        wr_time       = now_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next      = action;
                    pid_next      = process_id;
                    ev_next       = event_id;
                    now_next      = time_ns;
                    issue_next    = '0;
                    pend_next     = 1'b0;
                    cmd_next.op      = elh_pkg::OP_PASS;
                    cmd_next.status  = elh_pkg::ST_IGNORED;
                    cmd_next.hist_id = event_id[elh_pkg::HID_W-1:0];
                    cmd_next.bucket  = 6'd0;
                    state_next       = S_EMIT;
                    if ((action == elh_pkg::ACT_START) || (action == elh_pkg::ACT_END))
                    begin
                        if (pass)
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (action == elh_pkg::ACT_READ)
                    begin
                        if (in_ev_in_range && sel_in_range)
                        begin
                            cmd_next.op     = elh_pkg::OP_READ;
                            cmd_next.status = elh_pkg::ST_READ;
                            cmd_next.bucket = bucket_select;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    hit_idx_next = pend_idx_reg;
                    if (act_reg == elh_pkg::ACT_START)
                    begin
                        // Repeated start: only the time is refreshed.
                        wr_en           = 1'b1;
                        wr_addr         = pend_idx_reg;
                        cmd_next.status = elh_pkg::ST_STORED;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        diff_next = now_reg - time_q;
                        fill_next = fill_reg - elh_pkg::TAB_CW'(1);
                        thr_next  = elh_pkg::THR_W'(2 * elh_pkg::NS_PER_US);
                        bkt_next  = 6'd0;
                        if (elh_pkg::TAB_CW'(pend_idx_reg) != fill_reg - elh_pkg::TAB_CW'(1))
                        begin
                            state_next = S_MOVE_RD;
                        end
                        else if (ev_in_range)
                        begin
                            state_next = S_LOG;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                end
                else if (!issuing && !pend_reg)
                begin
                    state_next = S_EMIT;
                    if (act_reg == elh_pkg::ACT_START)
                    begin
                        if (fill_reg == elh_pkg::TAB_CW'(elh_pkg::TABLE_ENTRIES))
                        begin
                            cmd_next.status = elh_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_owner_en     = 1'b1;
                            fill_next       = fill_reg + elh_pkg::TAB_CW'(1);
                            cmd_next.status = elh_pkg::ST_STORED;
                        end
                    end
                    else
                    begin
                        cmd_next.status = elh_pkg::ST_NO_START;
                    end
                end
                else
                begin
                    pend_next     = issuing;
                    pend_idx_next = issue_reg[elh_pkg::TAB_AW-1:0];
                    if (issuing)
                    begin
                        issue_next = issue_reg + elh_pkg::TAB_CW'(1);
                    end
                end
            end

            S_MOVE_RD:
            begin
                rd_addr    = fill_reg[elh_pkg::TAB_AW-1:0];
                state_next = S_MOVE_WR;
            end

            S_MOVE_WR:
            begin
                wr_en       = 1'b1;
                wr_owner_en = 1'b1;
                wr_addr     = hit_idx_reg;
                wr_owner    = owner_q;
                wr_time     = time_q;
                state_next  = ev_in_range ? S_LOG : S_EMIT;
            end

            S_LOG:
            begin
                if ((bkt_reg == 6'(elh_pkg::HIST_BUCKETS - 1)) ||
                    ({10'd0, diff_reg} < thr_reg))
                begin
                    cmd_next.op     = elh_pkg::OP_COUNT;
                    cmd_next.status = elh_pkg::ST_COUNTED;
                    cmd_next.bucket = bkt_reg;
                    state_next      = S_EMIT;
                end
                else
                begin
                    bkt_next = bkt_reg + 6'd1;
                    thr_next = thr_reg << 1;
                end
            end

            S_EMIT:
            begin
                if (!cmd_full)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            issue_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        pid_reg      <= pid_next;
        ev_reg       <= ev_next;
        now_reg      <= now_next;
        pend_idx_reg <= pend_idx_next;
        hit_idx_reg  <= hit_idx_next;
        diff_reg     <= diff_next;
        thr_reg      <= thr_next;
        bkt_reg      <= bkt_next;
        cmd_reg      <= cmd_next;
    end

    // Start table storage: entries below the fill count are live.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[wr_addr] <= wr_time;
        end
        if (wr_en && wr_owner_en)
        begin
            owner_mem[wr_addr] <= wr_owner;
        end
        owner_q <= owner_mem[rd_addr];
        time_q  <= time_mem[rd_addr];
    end

endmodule

// ===== src/elh_back.sv =====
// ----------------------------------------------------------------------------
// Histogram back end
// Clears the counter memory after reset, then runs each queued command:
// a pass-through status, a counter read, or a counter read-modify-write.
// ----------------------------------------------------------------------------
module elh_back (
    input  logic                  clk,
    input  logic                  rst_n,
    output elh_pkg::back_status_t back_status,
    input  logic                  cmd_empty,
    input  elh_pkg::cmd_t         cmd,
    output logic                  cmd_pop,
    output logic                  res_valid,
    output elh_pkg::result_t      res,
    input  logic                  res_pop
);

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_DATA
    } state_t;

    state_t                      state_reg;
    logic [elh_pkg::HADDR_W-1:0] clr_addr_reg;
    logic [elh_pkg::HADDR_W-1:0] addr_reg;
    elh_pkg::op_t                op_reg;
    logic [5:0]                  bkt_reg;
    logic                        res_valid_reg;
    elh_pkg::result_t            res_reg;

    logic [63:0]                 hist_mem [elh_pkg::HIST_DEPTH];
    logic [63:0]                 rd_q;
    logic [elh_pkg::HADDR_W-1:0] cmd_addr;
    logic                        wr_en;
    logic [elh_pkg::HADDR_W-1:0] wr_addr;
    logic [63:0]                 wr_data;
    logic [63:0]                 incr;

    assign back_status.clearing = (state_reg == B_CLEAR);
    assign cmd_pop   = (state_reg == B_IDLE) && !cmd_empty && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign incr      = rd_q + 64'd1;

    assign cmd_addr = elh_pkg::HADDR_W'(
        elh_pkg::HADDR_W'(cmd.hist_id) * elh_pkg::HADDR_W'(elh_pkg::HIST_BUCKETS) +
        elh_pkg::HADDR_W'(cmd.bucket));

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = incr;
        if (state_reg == B_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = 64'd0;
        end
        else if ((state_reg == B_DATA) && (op_reg == elh_pkg::OP_COUNT))
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_addr_reg  <= '0;
            addr_reg      <= '0;
            op_reg        <= elh_pkg::OP_PASS;
            bkt_reg       <= 6'd0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (res_pop && res_valid_reg)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + elh_pkg::HADDR_W'(1);
                    if (clr_addr_reg == elh_pkg::HADDR_W'(elh_pkg::HIST_DEPTH - 1))
                    begin
                        state_reg <= B_IDLE;
                    end
                end

                B_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        addr_reg <= cmd_addr;
                        op_reg   <= cmd.op;
                        bkt_reg  <= cmd.bucket;
                        if (cmd.op == elh_pkg::OP_PASS)
                        begin
                            res_reg.status <= cmd.status;
                            res_reg.bucket <= 6'd0;
                            res_reg.count  <= 64'd0;
                            res_valid_reg  <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= B_DATA;
                        end
                    end
                end

                B_DATA:
                begin
                    res_reg.bucket <= bkt_reg;
                    if (op_reg == elh_pkg::OP_COUNT)
                    begin
                        res_reg.status <= elh_pkg::ST_COUNTED;
                        res_reg.count  <= incr;
                    end
                    else
                    begin
                        res_reg.status <= elh_pkg::ST_READ;
                        res_reg.count  <= rd_q;
                    end
                    res_valid_reg <= 1'b1;
                    state_reg     <= B_IDLE;
                end

                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
        rd_q <= hist_mem[cmd_addr];
    end

endmodule

// ===== src/event_latency_log2_histogram.sv =====
// ----------------------------------------------------------------------------
// Event latency log2 histogram
// Pairs event starts and ends per process, bins each latency in microseconds
// into a per-event floor-log2 histogram, and reads counters back on request.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Beat contents
//   -------   -------------------   ------------------------------------------
//   input     push / full           action, process_id, event_id, time_ns,
//                                   bucket_select
//   result    empty / pop           status, bucket, bucket_count
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// An item that needs no table lookup goes from idle straight to the output
// stage. A start or end walks the live part of the start table, up to 1024
// entries, one entry per cycle through its single read port. An end adds a
// bucket search over up to 36 buckets, one threshold compare per cycle, and a
// read state and a write state to move the last live entry into the freed
// slot. The histogram back end answers a pass-through status from idle and
// takes a counter read or update through its data state.
// After reset the counter memory of 18432 entries is swept to zero, one entry
// per cycle; full stays high during the sweep while configuration writes
// are still taken. A result that is not popped stalls the back end; the
// two-entry command queue and the front end's output stage then let up to
// three more beats in before full stays high.
//
module event_latency_log2_histogram (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [31:0] process_id,
    input  logic [15:0] event_id,
    input  logic [63:0] time_ns,
    input  logic [5:0]  bucket_select,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [5:0]  bucket,
    output logic [63:0] bucket_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0]           only_process_reg;
    logic [15:0]           only_event_reg;

    elh_pkg::back_status_t back_status;
    elh_pkg::cmd_t         front_cmd;
    elh_pkg::cmd_t         queue_cmd;
    logic                  cmd_push;
    logic                  cmd_full;
    logic                  cmd_pop;
    logic                  cmd_empty;
    logic                  res_valid;
    elh_pkg::result_t      res;

    // Filter registers are always writable; the host must only change them idle, and the block does not enforce it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            only_process_reg <= 32'd0;
            only_event_reg   <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == elh_pkg::CFG_ONLY_PROCESS)
            begin
                only_process_reg <= cfg_data;
            end
            else if (cfg_index == elh_pkg::CFG_ONLY_EVENT)
            begin
                only_event_reg <= cfg_data[15:0];
            end
        end
    end

    // The front end classifies each beat and owns the start table.
    elh_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .action        (action),
        .process_id    (process_id),
        .event_id      (event_id),
        .time_ns       (time_ns),
        .bucket_select (bucket_select),
        .only_process  (only_process_reg),
        .only_event    (only_event_reg),
        .back_status   (back_status),
        .cmd_push      (cmd_push),
        .cmd           (front_cmd),
        .cmd_full      (cmd_full)
    );

    // Every beat leaves exactly one command, so results keep input order.
    elh_cmd_fifo u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .full  (cmd_full),
        .din   (front_cmd),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .dout  (queue_cmd)
    );

    // The back end owns the counter memory and the result register.
    elh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .back_status (back_status),
        .cmd_empty   (cmd_empty),
        .cmd         (queue_cmd),
        .cmd_pop     (cmd_pop),
        .res_valid   (res_valid),
        .res         (res),
        .res_pop     (pop)
    );

    assign empty        = !res_valid;
    assign status       = res.status;
    assign bucket       = res.bucket;
    assign bucket_count = res.count;

    // No beat may enter while the counter memory is being swept.
    a_no_accept_in_clear : assert property (
        @(posedge clk) disable iff (!rst_n)
        back_status.clearing |-> full)
    else $error("input accepted during counter sweep");

    // Bucket and count carry data only for counted and read results.
    a_idle_fields_zero : assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && (status != elh_pkg::ST_COUNTED) && (status != elh_pkg::ST_READ))
        |-> ((bucket == 6'd0) && (bucket_count == 64'd0)))
    else $error("stray bucket data on a plain status result");

    // Any shown bucket lies inside the histogram.
    a_bucket_range : assert property (
        @(posedge clk) disable iff (!rst_n)
        !empty |-> (7'(bucket) < 7'(elh_pkg::HIST_BUCKETS)))
    else $error("bucket out of range");

    // A waiting result holds until it is popped.
    a_result_holds : assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(bucket_count) && $stable(status)))
    else $error("waiting result changed before pop");

endmodule

// ===== verif/event_latency_log2_histogram_tb.sv =====
// ----------------------------------------------------------------------------
// Event latency log2 histogram testbench
// Drives start, end, read and no-action beats and filter writes with random
// pacing on both sides. A local copy of the start table and the per-event
// histograms predicts every result beat, and the result beats are checked in order, field by field.
// ----------------------------------------------------------------------------
module event_latency_log2_histogram_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // One input beat as the driver sees it.
    typedef struct {
        logic [1:0]  act;
        logic [31:0] pid;
        logic [15:0] ev;
        logic [63:0] tns;
        logic [5:0]  sel;
    } beat_t;

    // One queued job, a configuration write or an input beat; marked so the driver can tell it apart.
    typedef struct {
        bit          is_cfg;
        logic [3:0]  idx;
        logic [31:0] data;
        beat_t       b;
    } job_t;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int DRAIN_CYCLES   = 1200;
    localparam int N_RANDOM       = 930;
    localparam int CLEAN_TAIL     = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  action = '0;
    logic [31:0] process_id = '0;
    logic [15:0] event_id = '0;
    logic [63:0] time_ns = '0;
    logic [5:0]  bucket_select = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  status;
    logic [5:0]  bucket;
    logic [63:0] bucket_count;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    event_latency_log2_histogram u_dut (.*);

    always #1 clk = ~clk;

    // Predictor state: filters, start table and histogram counters.
    logic [31:0] watch_pid;
    logic [15:0] watch_ev;
    bit          slot_live [elh_pkg::TABLE_ENTRIES];
    logic [31:0] slot_pid [elh_pkg::TABLE_ENTRIES];
    logic [63:0] slot_time [elh_pkg::TABLE_ENTRIES];
    logic [63:0] hist_count [elh_pkg::HIST_DEPTH];

    elh_pkg::result_t expected_results [$];
    job_t        pending_jobs [$];
    int          n_fail = 0;
    int          n_beats_in = 0;
    int          n_beats_out = 0;
    int          n_counted = 0;
    int          n_full = 0;
    bit          calm = 1'b0;   // no idling in the last part of the run
    int          idle_cycles = 0;
    int          push_gap = 0;
    int          pop_gap = 0;
    int          quiet = 0;

    // Handshake values seen at the last rising edge.
    logic full_q = 1'b1;
    logic cfg_ready_q = 1'b0;

    // Works out the result of one accepted beat and updates the local state.
    function automatic elh_pkg::result_t predict_latency(beat_t b);
        elh_pkg::result_t r;
        int          hit;
        int          free_slot;
        logic [63:0] us;
        int          lg;
        int          idx;
        bit          pass;
        r = '{status: elh_pkg::ST_IGNORED, bucket: '0, count: '0};
        hit = -1;
        free_slot = -1;
        if (b.act == elh_pkg::ACT_START || b.act == elh_pkg::ACT_END) begin
            pass = !(watch_ev != 0 && b.ev != watch_ev) &&
                   !(watch_pid != 0 && b.pid != watch_pid);
            if (!pass)
                return r;
            for (int i = 0; i < elh_pkg::TABLE_ENTRIES; i++)
            begin
                if (slot_live[i] && slot_pid[i] == b.pid && hit < 0)
                    hit = i;
                if (!slot_live[i] && free_slot < 0)
                    free_slot = i;
            end
            if (b.act == elh_pkg::ACT_START) begin
                if (hit < 0)
                    hit = free_slot;
                if (hit < 0) begin
                    r.status = elh_pkg::ST_FULL;
                    n_full++;
                end
                else begin
                    slot_live[hit] = 1'b1;
                    slot_pid[hit] = b.pid;
                    slot_time[hit] = b.tns;
                    r.status = elh_pkg::ST_STORED;
                end
            end
            else if (hit < 0)
                r.status = elh_pkg::ST_NO_START;
            else begin
                slot_live[hit] = 1'b0;
                if (b.ev < elh_pkg::HIST_IDS) begin
                    us = (b.tns - slot_time[hit]) / 64'd1000;
                    lg = 0;
                    while (us > 1) begin
                        us = us >> 1;
                        lg++;
                    end
                    if (lg > elh_pkg::HIST_BUCKETS - 1)
                        lg = elh_pkg::HIST_BUCKETS - 1;
                    idx = b.ev * elh_pkg::HIST_BUCKETS + lg;
                    hist_count[idx] = hist_count[idx] + 64'd1;
                    r.status = elh_pkg::ST_COUNTED;
                    r.bucket = lg[5:0];
                    r.count = hist_count[idx];
                    n_counted++;
                end
            end
        end
        else if (b.act == elh_pkg::ACT_READ && b.ev < elh_pkg::HIST_IDS &&
                 b.sel < elh_pkg::HIST_BUCKETS) begin
            r.status = elh_pkg::ST_READ;
            r.bucket = b.sel;
            r.count = hist_count[b.ev * elh_pkg::HIST_BUCKETS + b.sel];
        end
        return r;
    endfunction

    // A configuration write waits until the block is idle: nothing expected
    // and a quiet period after the last result so that no beat is in flight.
    function automatic bit cfg_busy_hold();
        if (pending_jobs.size() == 0 || !pending_jobs[0].is_cfg)
            return 1'b0;
        return (expected_results.size() != 0) || push || (quiet < DRAIN_CYCLES);
    endfunction

    // Driver: at the falling edge, presents the head of the queue, holding
    // each beat until accepted. A burst counter makes random gaps.
    always @(negedge clk)
    begin
        logic push_v;
        logic cfg_v;
        job_t j;
        if (rst_n) begin
            push_v = push;
            cfg_v = cfg_valid;
            if (push_v && !full_q)
                push_v = 1'b0;
            if (cfg_v && cfg_ready_q)
                cfg_v = 1'b0;
            if (!push_v && !cfg_v) begin
                if (push_gap > 0)
                    push_gap <= push_gap - 1;
                else if (pending_jobs.size() > 0 && !cfg_busy_hold()) begin
                    j = pending_jobs.pop_front();
                    if (j.is_cfg) begin
                        cfg_index <= j.idx;
                        cfg_data <= j.data;
                        cfg_v = 1'b1;
                    end
                    else begin
                        action <= j.b.act;
                        process_id <= j.b.pid;
                        event_id <= j.b.ev;
                        time_ns <= j.b.tns;
                        bucket_select <= j.b.sel;
                        push_v = 1'b1;
                    end
                    if (!calm && $urandom_range(0, 9) == 0)
                        push_gap <= $urandom_range(1, 19);
                end
            end
            push <= push_v;
            cfg_valid <= cfg_v;
        end
    end

    // Monitor: at the rising edge, records accepted beats and checks results.
    always @(posedge clk)
    begin
        beat_t            b;
        elh_pkg::result_t e;
        int               idle_v;
        full_q <= full;
        cfg_ready_q <= cfg_ready;
        if (rst_n) begin
            idle_v = idle_cycles + 1;
            quiet <= (push || expected_results.size() != 0) ? 0 : quiet + 1;
            if (cfg_valid && cfg_ready) begin
                idle_v = 0;
                if (cfg_index == elh_pkg::CFG_ONLY_PROCESS)
                    watch_pid = cfg_data;
                else if (cfg_index == elh_pkg::CFG_ONLY_EVENT)
                    watch_ev = cfg_data[15:0];
            end
            if (push && !full) begin
                idle_v = 0;
                b = '{act: action, pid: process_id, ev: event_id, tns: time_ns,
                      sel: bucket_select};
                expected_results.push_back(predict_latency(b));
                n_beats_in++;
            end
            if (pop && !empty) begin
                idle_v = 0;
                n_beats_out++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat status %0d bucket %0d count %0d",
                             $realtime, status, bucket, bucket_count);
                    n_fail++;
                end
                else begin
                    e = expected_results.pop_front();
                    if (status !== e.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, e.status, status);
                        n_fail++;
                    end
                    if (bucket !== e.bucket) begin
                        $display("%0t: bucket expected %0d actual %0d",
                                 $realtime, e.bucket, bucket);
                        n_fail++;
                    end
                    if (bucket_count !== e.count) begin
                        $display("%0t: bucket_count expected %0d actual %0d",
                                 $realtime, e.count, bucket_count);
                        n_fail++;
                    end
                end
            end
            idle_cycles <= idle_v;
        end
    end

    // Result side pacing: pop changes only at the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_gap > 0) begin
            pop_gap <= pop_gap - 1;
            pop <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 11) == 0) begin
            pop_gap <= $urandom_range(1, 19);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    // Watchdog: the sweep after reset is long, so the limit covers it.
    always @(posedge clk)
    begin
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void add_beat(logic [1:0] a, logic [31:0] p, logic [15:0] ev,
                                     logic [63:0] t, logic [5:0] s);
        job_t j;
        j.is_cfg = 1'b0;
        j.idx = '0;
        j.data = '0;
        j.b = '{act: a, pid: p, ev: ev, tns: t, sel: s};
        pending_jobs.push_back(j);
    endfunction

    function automatic void add_cfg(logic [3:0] i, logic [31:0] d);
        job_t j;
        j.is_cfg = 1'b1;
        j.idx = i;
        j.data = d;
        j.b = '{act: '0, pid: '0, ev: '0, tns: '0, sel: '0};
        pending_jobs.push_back(j);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Picks a latency spread over all buckets, small ones favored.
    function automatic logic [63:0] rand_latency();
        int sh;
        sh = $urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 24);
        return rand64() >> (63 - sh);
    endfunction

    // A phase of random beats. Most are start/end pairs over a small pool of
    // processes so that ends usually find their start; the rest is noise.
    task automatic add_random_phase(int n, logic [31:0] fpid, logic [15:0] fev);
        logic [31:0] pool [8];
        logic [63:0] clock_ns;
        int          k;
        logic [31:0] p;
        logic [15:0] ev;
        clock_ns = rand64();
        for (int i = 0; i < 8; i++)
            pool[i] = (i == 0 && fpid != 0) ? fpid : $urandom();
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            p = pool[$urandom_range(0, 7)];
            ev = (fev != 0 && $urandom_range(0, 3) != 0) ? fev : 16'($urandom_range(0, 600));
            if ($urandom_range(0, 15) == 0)
                ev = 16'($urandom());
            if (fpid != 0 && $urandom_range(0, 3) != 0)
                p = fpid;
            if (k < 40)
                add_beat(elh_pkg::ACT_START, p, ev, clock_ns, 6'($urandom()));
            else if (k < 80)
                add_beat(elh_pkg::ACT_END, p, ev, clock_ns, 6'($urandom()));
            else if (k < 93)
                add_beat(elh_pkg::ACT_READ, p, ev, rand64(),
                         $urandom_range(0, 3) == 0 ? 6'($urandom())
                                                   : 6'($urandom_range(0, 35)));
            else
                add_beat(elh_pkg::ACT_NONE, $urandom(), 16'($urandom()), rand64(),
                         6'($urandom()));
            clock_ns = clock_ns + rand_latency();
        end
    endtask

    initial
    begin
        watch_pid = '0;
        watch_ev = '0;
        for (int i = 0; i < elh_pkg::TABLE_ENTRIES; i++)
            slot_live[i] = 1'b0;
        for (int i = 0; i < elh_pkg::HIST_DEPTH; i++)
            hist_count[i] = '0;

        // Directed part: extremes, every action and every special case.
        add_beat(elh_pkg::ACT_READ, 32'd0, 16'd0, 64'd0, 6'd0);
        add_beat(elh_pkg::ACT_END, 32'd7, 16'd3, 64'd0, 6'd0);       // end without start
        add_beat(elh_pkg::ACT_START, 32'hFFFF_FFFF, 16'd511, 64'hFFFF_FFFF_FFFF_FF00, 6'd63);
        add_beat(elh_pkg::ACT_START, 32'hFFFF_FFFF, 16'd511, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
        add_beat(elh_pkg::ACT_END, 32'hFFFF_FFFF, 16'd511, 64'd1998, 6'd0); // wraps, 1999 ns
        add_beat(elh_pkg::ACT_START, 32'd0, 16'd0, 64'd5, 6'd0);
        add_beat(elh_pkg::ACT_END, 32'd0, 16'd0, 64'd5, 6'd0);       // zero latency
        add_beat(elh_pkg::ACT_START, 32'd1, 16'd1, 64'd0, 6'd0);
        add_beat(elh_pkg::ACT_END, 32'd1, 16'd1, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0); // saturated
        add_beat(elh_pkg::ACT_START, 32'd2, 16'd600, 64'd0, 6'd0);
        add_beat(elh_pkg::ACT_END, 32'd2, 16'hFFFF, 64'd100000, 6'd0); // id out of range
        add_beat(elh_pkg::ACT_END, 32'd2, 16'd1, 64'd100000, 6'd0);  // entry is gone
        add_beat(elh_pkg::ACT_READ, 32'd0, 16'd1, 64'd0, 6'd35);
        add_beat(elh_pkg::ACT_READ, 32'd0, 16'd511, 64'd0, 6'd0);
        add_beat(elh_pkg::ACT_READ, 32'd0, 16'd512, 64'd0, 6'd0);    // read out of range
        add_beat(elh_pkg::ACT_READ, 32'd0, 16'd1, 64'd0, 6'd36);
        add_beat(elh_pkg::ACT_READ, 32'd0, 16'd1, 64'd0, 6'd63);
        add_beat(elh_pkg::ACT_NONE, 32'hFFFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
        add_beat(elh_pkg::ACT_START, 32'd9, 16'd4, 64'd1000, 6'd0);
        add_beat(elh_pkg::ACT_START, 32'd9, 16'd4, 64'd50000, 6'd0); // repeated start
        add_beat(elh_pkg::ACT_END, 32'd9, 16'd4, 64'd51000, 6'd0);

        // Filters at their extremes, with one matching start/end pair and one filtered start.
        add_cfg(elh_pkg::CFG_ONLY_PROCESS, 32'hFFFF_FFFF);
        add_cfg(elh_pkg::CFG_ONLY_EVENT, 32'h0000_FFFF);
        add_beat(elh_pkg::ACT_START, 32'hFFFF_FFFF, 16'hFFFF, 64'd0, 6'd0);
        add_beat(elh_pkg::ACT_START, 32'd5, 16'hFFFF, 64'd0, 6'd0);  // filtered
        add_beat(elh_pkg::ACT_END, 32'hFFFF_FFFF, 16'hFFFF, 64'd4000, 6'd0);
        add_random_phase(150, 32'hFFFF_FFFF, 16'hFFFF);
        add_cfg(elh_pkg::CFG_ONLY_PROCESS, $urandom());
        add_cfg(elh_pkg::CFG_ONLY_EVENT, $urandom_range(1, 511));
        add_random_phase(150, 32'd0, 16'd0);
        add_cfg(elh_pkg::CFG_ONLY_PROCESS, 32'd0);
        add_random_phase(150, 32'd0, 16'd0);
        add_cfg(elh_pkg::CFG_ONLY_EVENT, 32'd0);
        add_random_phase(N_RANDOM - 450 - CLEAN_TAIL, 32'd0, 16'd0);
        add_random_phase(CLEAN_TAIL, 32'd0, 16'd0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_jobs.size() <= CLEAN_TAIL);
        calm = 1'b1;
        wait (pending_jobs.size() == 0 && !push);
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input beats and %0d result beats, %0d counted latencies,",
                 n_beats_in, n_beats_out, n_counted);
        $display("%0d table-full starts, across four filter settings.", n_full);
        if (n_fail == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else begin
            if (expected_results.size() != 0)
                $display("%0t: %0d expected results never arrived",
                         $realtime, expected_results.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
